// File: hw/rtl/msr_pkg.sv
// Shared types and constants for the multi-mode string recognizer.
// No dependencies; every other RTL file imports this package.
package msr_pkg;

    typedef struct packed {
        logic [3:0] symbol;
        logic       terminator;
    } t_msr_in;

    typedef struct packed {
        logic       accepted;
        logic [5:0] string_length;
    } t_msr_out;

    // Per-string trackers that do not depend on the length parameter.
    typedef struct packed {
        logic       length_odd;
        logic [2:0] zero_count_capped;
        logic       zero_parity;
        logic [1:0] zero_mod_three;
        logic       one_parity;
        logic [1:0] first_two_bits;
        logic [2:0] recent_three_bits;
        logic [1:0] residue_three;
        logic [1:0] residue_four;
        logic [2:0] substring_seen_flags;
        logic [3:0] window_zero_history;
        logic       window_violation;
    } t_msr_state;

    localparam int MODE_W = 5;
    localparam int LEN_W  = 6;

    localparam logic [MODE_W-1:0] MODE_STARTS_0       = 5'd1;
    localparam logic [MODE_W-1:0] MODE_LEN_TWO        = 5'd2;
    localparam logic [MODE_W-1:0] MODE_LEN_EVEN       = 5'd3;
    localparam logic [MODE_W-1:0] MODE_HAS_11         = 5'd4;
    localparam logic [MODE_W-1:0] MODE_ZEROS_EQ3      = 5'd5;
    localparam logic [MODE_W-1:0] MODE_ZEROS_LE3      = 5'd6;
    localparam logic [MODE_W-1:0] MODE_ZEROS_GE3      = 5'd7;
    localparam logic [MODE_W-1:0] MODE_ZEROS_EVEN     = 5'd8;
    localparam logic [MODE_W-1:0] MODE_ZEROS_ODD      = 5'd9;
    localparam logic [MODE_W-1:0] MODE_STARTS_10      = 5'd10;
    localparam logic [MODE_W-1:0] MODE_ENDS_10        = 5'd11;
    localparam logic [MODE_W-1:0] MODE_HAS_10         = 5'd12;
    localparam logic [MODE_W-1:0] MODE_ZEROS_MOD3     = 5'd13;
    localparam logic [MODE_W-1:0] MODE_EDGE_01        = 5'd14;
    localparam logic [MODE_W-1:0] MODE_NO_EDGE_01     = 5'd15;
    localparam logic [MODE_W-1:0] MODE_EVEN_EVEN      = 5'd16;
    localparam logic [MODE_W-1:0] MODE_ODD_ODD        = 5'd17;
    localparam logic [MODE_W-1:0] MODE_EVEN0_ODD1     = 5'd18;
    localparam logic [MODE_W-1:0] MODE_BIN_DIV3       = 5'd19;
    localparam logic [MODE_W-1:0] MODE_BIN_DIV4       = 5'd20;
    localparam logic [MODE_W-1:0] MODE_HAS_000        = 5'd21;
    localparam logic [MODE_W-1:0] MODE_THIRD_LAST_1   = 5'd22;
    localparam logic [MODE_W-1:0] MODE_WINDOW_TWO0    = 5'd23;
    localparam logic [MODE_W-1:0] MODE_DEC_DIV3       = 5'd24;
    localparam logic [MODE_W-1:0] MODE_DEC_DIV4       = 5'd25;

    localparam logic [MODE_W-1:0] MODE_RESET          = MODE_STARTS_0;

    localparam logic [3:0] SYM_MAX_BIN = 4'd1;
    localparam logic [3:0] SYM_MAX_DEC = 4'd9;

    // Residue modulo 3 of a 4-bit value, two bits per entry, entry 0 lowest.
    localparam logic [31:0] MOD3_LUT = 32'b00100100_10010010_01001001_00100100;

    function automatic logic [1:0] msr_mod3(input logic [3:0] v);
        return MOD3_LUT[{v, 1'b0} +: 2];
    endfunction

endpackage

// File: hw/rtl/msr_tracker.sv
// Per-string tracker registers: counts, parities, residues and pattern flags.
// Depends on msr_pkg; cleared by a terminator beat.
module msr_tracker #(
    parameter int MAX_LENGTH = 63,
    parameter int CNT_W      = 6
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  msr_pkg::t_msr_in          i_beat,
    input  logic [msr_pkg::MODE_W-1:0] i_mode,
    output msr_pkg::t_msr_state       o_state,
    output logic [CNT_W-1:0]          o_count
);
    import msr_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LENGTH);

    t_msr_state       r_st, n_st;
    logic [CNT_W-1:0] r_count, n_count;

    logic       binary_mode, decimal_mode, take, is_bit, z;
    logic [2:0] hist_zeros;

    always_comb begin
        binary_mode = (i_mode inside {[MODE_STARTS_0:MODE_WINDOW_TWO0]});
        decimal_mode = (i_mode inside {MODE_DEC_DIV3, MODE_DEC_DIV4});
        is_bit = (i_beat.symbol <= SYM_MAX_BIN);
        take = !i_beat.terminator && ((binary_mode && is_bit)
               || (decimal_mode && (i_beat.symbol <= SYM_MAX_DEC)));
        z = !i_beat.symbol[0];
        hist_zeros = 3'(r_st.window_zero_history[0]) + 3'(r_st.window_zero_history[1])
                   + 3'(r_st.window_zero_history[2]) + 3'(r_st.window_zero_history[3]);

        n_st = r_st;
        n_count = r_count;
        if (i_fire && i_beat.terminator) begin
            n_st = '0;
            n_count = '0;
        end else if (i_fire && take) begin
            if (is_bit) begin
                if (r_count >= CNT_W'(1) && r_st.recent_three_bits[0]) begin
                    if (i_beat.symbol[0]) begin
                        n_st.substring_seen_flags[0] = 1'b1;
                    end else begin
                        n_st.substring_seen_flags[1] = 1'b1;
                    end
                end
                if (z && r_count >= CNT_W'(2) && r_st.recent_three_bits[1:0] == 2'b00) begin
                    n_st.substring_seen_flags[2] = 1'b1;
                end
                // The window of five ending here needs at least two zeros.
                if (r_count >= CNT_W'(4) && (hist_zeros + 3'(z)) < 3'd2) begin
                    n_st.window_violation = 1'b1;
                end
                n_st.window_zero_history = {r_st.window_zero_history[2:0], z};
                if (r_count == '0) begin
                    n_st.first_two_bits[1] = i_beat.symbol[0];
                end else if (r_count == CNT_W'(1)) begin
                    n_st.first_two_bits[0] = i_beat.symbol[0];
                end
                n_st.recent_three_bits = {r_st.recent_three_bits[1:0], i_beat.symbol[0]};
                if (z) begin
                    if (r_st.zero_count_capped != 3'd7) begin
                        n_st.zero_count_capped = r_st.zero_count_capped + 3'd1;
                    end
                    n_st.zero_parity = !r_st.zero_parity;
                    n_st.zero_mod_three = (r_st.zero_mod_three >= 2'd2) ? 2'd0
                                        : r_st.zero_mod_three + 2'd1;
                end else begin
                    n_st.one_parity = !r_st.one_parity;
                end
            end
            if (decimal_mode) begin
                n_st.residue_three = msr_mod3(4'(r_st.residue_three) + i_beat.symbol);
            end else begin
                n_st.residue_three = msr_mod3({1'b0, r_st.residue_three, 1'b0} + i_beat.symbol);
            end
            n_st.residue_four = 2'({r_st.residue_four[0], 1'b0} + i_beat.symbol[1:0]);
            n_st.length_odd = !r_st.length_odd;
            if (r_count < CNT_MAX) begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
            r_count <= '0;
        end else begin
            r_st <= n_st;
            r_count <= n_count;
        end
    end

    assign o_state = r_st;
    assign o_count = r_count;

endmodule

// File: hw/rtl/msr_verdict.sv
// Acceptance decision for the selected language from the current trackers.
// Depends on msr_pkg; purely combinational.
module msr_verdict #(
    parameter int CNT_W = 6
) (
    input  msr_pkg::t_msr_state        i_state,
    input  logic [CNT_W-1:0]           i_count,
    input  logic [msr_pkg::MODE_W-1:0] i_mode,
    output logic                       o_accepted
);
    import msr_pkg::*;

    logic two, begins01, ends01;

    always_comb begin
        two = (i_count >= CNT_W'(2));
        begins01 = two && i_state.first_two_bits == 2'b01;
        ends01 = two && i_state.recent_three_bits[1:0] == 2'b01;
        case (i_mode)
            MODE_STARTS_0:     o_accepted = i_count >= CNT_W'(1) && !i_state.first_two_bits[1];
            MODE_LEN_TWO:      o_accepted = i_count == CNT_W'(2);
            MODE_LEN_EVEN:     o_accepted = !i_state.length_odd;
            MODE_HAS_11:       o_accepted = i_state.substring_seen_flags[0];
            MODE_ZEROS_EQ3:    o_accepted = i_state.zero_count_capped == 3'd3;
            MODE_ZEROS_LE3:    o_accepted = i_state.zero_count_capped <= 3'd3;
            MODE_ZEROS_GE3:    o_accepted = i_state.zero_count_capped >= 3'd3;
            MODE_ZEROS_EVEN:   o_accepted = !i_state.zero_parity;
            MODE_ZEROS_ODD:    o_accepted = i_state.zero_parity;
            MODE_STARTS_10:    o_accepted = two && i_state.first_two_bits == 2'b10;
            MODE_ENDS_10:      o_accepted = two && i_state.recent_three_bits[1:0] == 2'b10;
            MODE_HAS_10:       o_accepted = i_state.substring_seen_flags[1];
            MODE_ZEROS_MOD3:   o_accepted = i_state.zero_mod_three == 2'd0;
            MODE_EDGE_01:      o_accepted = begins01 || ends01;
            MODE_NO_EDGE_01:   o_accepted = !(begins01 || ends01);
            MODE_EVEN_EVEN:    o_accepted = !i_state.zero_parity && !i_state.one_parity;
            MODE_ODD_ODD:      o_accepted = i_state.zero_parity && i_state.one_parity;
            MODE_EVEN0_ODD1:   o_accepted = !i_state.zero_parity && i_state.one_parity;
            MODE_BIN_DIV3:     o_accepted = i_state.residue_three == 2'd0;
            MODE_BIN_DIV4:     o_accepted = i_state.residue_four == 2'd0;
            MODE_HAS_000:      o_accepted = i_state.substring_seen_flags[2];
            MODE_THIRD_LAST_1: o_accepted = i_count >= CNT_W'(3) && i_state.recent_three_bits[2];
            MODE_WINDOW_TWO0:  o_accepted = i_count >= CNT_W'(5) && !i_state.window_violation;
            MODE_DEC_DIV3:     o_accepted = i_state.residue_three == 2'd0;
            MODE_DEC_DIV4:     o_accepted = i_state.residue_four == 2'd0;
            default:           o_accepted = 1'b0;
        endcase
    end

endmodule

// File: hw/rtl/multi_mode_string_recognizer.sv
// Top level of the multi-mode string recognizer: input stage, mode register,
// result register. Depends on msr_pkg, msr_tracker and msr_verdict.
//
//   channel | direction | beat             | handshake
//   --------+-----------+------------------+---------------------------
//   in      | input     | t_msr_in         | i_in_valid / o_in_ready
//   out     | output    | t_msr_out        | o_out_valid / i_out_ready
//   cfg     | input     | language mode    | i_cfg_valid / o_cfg_ready
//
// One beat per cycle is accepted while no terminator waits in the input register;
// a terminator beat's result passes the input register, then the result register.
// Reset clears the trackers and sets the language mode to 1.
// A held result stalls only terminator beats in the input register; symbol
// beats keep flowing underneath a waiting result.
module multi_mode_string_recognizer #(
    parameter int MAX_LENGTH = 63
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  msr_pkg::t_msr_in           i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output msr_pkg::t_msr_out          o_out,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [msr_pkg::MODE_W-1:0] i_cfg_data
);
    import msr_pkg::*;

    localparam int CNT_W = $clog2(MAX_LENGTH + 1);

    logic [MODE_W-1:0] r_mode;
    logic              r_s1_valid;
    t_msr_in           r_s1;
    logic              r_out_valid;
    t_msr_out          r_out;

    t_msr_state        trk_state;
    logic [CNT_W-1:0]  trk_count;
    logic [CNT_W+LEN_W-1:0] count_ext;
    logic              verdict;
    logic              out_free, s1_fire;

    assign out_free = !r_out_valid || i_out_ready;
    assign s1_fire = r_s1_valid && (!r_s1.terminator || out_free);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign o_cfg_ready = 1'b1;
    assign count_ext = {{LEN_W{1'b0}}, trk_count};

    msr_tracker #(
        .MAX_LENGTH(MAX_LENGTH),
        .CNT_W(CNT_W)
    ) u_tracker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_fire(s1_fire),
        .i_beat(r_s1),
        .i_mode(r_mode),
        .o_state(trk_state),
        .o_count(trk_count)
    );

    msr_verdict #(
        .CNT_W(CNT_W)
    ) u_verdict (
        .i_state(trk_state),
        .i_count(trk_count),
        .i_mode(r_mode),
        .o_accepted(verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
            r_s1_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_fire && r_s1.terminator) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1 <= i_in;
        end
        if (s1_fire && r_s1.terminator) begin
            r_out.accepted <= verdict;
            r_out.string_length <= count_ext[LEN_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out = r_out;

endmodule

// File: hw/rtl/msr_checker.sv
// Port-level checks for the multi-mode string recognizer, bound to the top.
// Depends on msr_pkg and the top level's port list.
module msr_checker #(
    parameter int MAX_LENGTH = 63
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input msr_pkg::t_msr_in           i_in,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input msr_pkg::t_msr_out          o_out,
    input logic                       i_cfg_valid,
    input logic                       o_cfg_ready
);
    import msr_pkg::*;

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // The reported length never passes the saturation limit.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (MAX_LENGTH > 63 || 32'(o_out.string_length) <= MAX_LENGTH))
        else $error("string length above saturation limit");

    // A fresh result always traces back to a terminator beat taken at the input port.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready && i_in.terminator, 2))
        else $error("result without a terminator beat");

    // The mode register never blocks a write.
    a_cfg_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write refused");

endmodule

bind multi_mode_string_recognizer msr_checker #(.MAX_LENGTH(MAX_LENGTH)) u_msr_checker (.*);

// File: bench/tb_multi_mode_string_recognizer.sv
// Self-checking bench for multi_mode_string_recognizer: random strings under every
// language mode, with a predictor that computes each verdict. Needs msr_pkg and the RTL.
`timescale 1ns / 100ps

module tb_multi_mode_string_recognizer;
    import msr_pkg::*;

    localparam logic [MODE_W-1:0] MODE_NONE = 5'd0;
    localparam logic [MODE_W-1:0] MODE_TOP  = 5'd31;
    localparam int STRING_LEN_MAX = 63;
    localparam int USEFUL_BEATS   = 700;

    // Everything the recognizer remembers about the string so far.
    typedef struct packed {
        logic [5:0] sym_count;
        logic       len_odd;
        logic [2:0] zero_capped;
        logic       zero_par;
        logic [1:0] zero_mod3;
        logic       one_par;
        logic [1:0] first_two;
        logic [2:0] recent;
        logic [1:0] res3;
        logic [1:0] res4;
        logic [2:0] seen;
        logic [3:0] zero_hist;
        logic       violation;
    } t_string_track;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    t_msr_in           in_beat = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_msr_out          out_beat;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [MODE_W-1:0] cfg_data = '0;

    t_msr_in           pending_beats[$];
    t_msr_out          verdict_queue[$];
    t_string_track     trk = '0;
    logic [MODE_W-1:0] lang_mode = MODE_RESET;
    logic [MODE_W-1:0] gen_mode = MODE_RESET;
    int unsigned       beats_pushed = 0;
    int unsigned       beats_taken = 0;
    int unsigned       useful_beats = 0;
    int unsigned       fail_count = 0;
    int unsigned       burst_left = 1;
    int unsigned       gap_left = 0;
    int unsigned       gap_max = 0;
    logic [15:0]       recv_pattern = 16'hFFFF;
    logic [3:0]        recv_phase = '0;

    multi_mode_string_recognizer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic symbol_taken(logic [MODE_W-1:0] m, logic [3:0] s);
        logic binary_m, decimal_m;
        binary_m  = m >= MODE_STARTS_0 && m <= MODE_WINDOW_TWO0;
        decimal_m = m == MODE_DEC_DIV3 || m == MODE_DEC_DIV4;
        return (binary_m && s <= SYM_MAX_BIN) || (decimal_m && s <= SYM_MAX_DEC);
    endfunction

    function automatic logic string_verdict(logic [MODE_W-1:0] m, t_string_track t);
        logic two, begins01, ends01;
        two      = t.sym_count >= 2;
        begins01 = two && t.first_two == 2'b01;
        ends01   = two && t.recent[1:0] == 2'b01;
        case (m)
            MODE_STARTS_0:     return t.sym_count >= 1 && !t.first_two[1];
            MODE_LEN_TWO:      return t.sym_count == 6'd2;
            MODE_LEN_EVEN:     return !t.len_odd;
            MODE_HAS_11:       return t.seen[0];
            MODE_ZEROS_EQ3:    return t.zero_capped == 3'd3;
            MODE_ZEROS_LE3:    return t.zero_capped <= 3'd3;
            MODE_ZEROS_GE3:    return t.zero_capped >= 3'd3;
            MODE_ZEROS_EVEN:   return !t.zero_par;
            MODE_ZEROS_ODD:    return t.zero_par;
            MODE_STARTS_10:    return two && t.first_two == 2'b10;
            MODE_ENDS_10:      return two && t.recent[1:0] == 2'b10;
            MODE_HAS_10:       return t.seen[1];
            MODE_ZEROS_MOD3:   return t.zero_mod3 == 2'd0;
            MODE_EDGE_01:      return begins01 || ends01;
            MODE_NO_EDGE_01:   return !(begins01 || ends01);
            MODE_EVEN_EVEN:    return !t.zero_par && !t.one_par;
            MODE_ODD_ODD:      return t.zero_par && t.one_par;
            MODE_EVEN0_ODD1:   return !t.zero_par && t.one_par;
            MODE_BIN_DIV3:     return t.res3 == 2'd0;
            MODE_BIN_DIV4:     return t.res4 == 2'd0;
            MODE_HAS_000:      return t.seen[2];
            MODE_THIRD_LAST_1: return t.sym_count >= 3 && t.recent[2];
            MODE_WINDOW_TWO0:  return t.sym_count >= 5 && !t.violation;
            MODE_DEC_DIV3:     return t.res3 == 2'd0;
            MODE_DEC_DIV4:     return t.res4 == 2'd0;
            default:           return 1'b0;
        endcase
    endfunction

    // Advances the string trackers by one accepted beat; a terminator queues a verdict.
    task automatic apply_beat(t_msr_in beat);
        t_msr_out    res;
        logic        bit_v, zero_v, decimal_m;
        int unsigned sym;
        sym = 32'(beat.symbol);
        if (beat.terminator) begin
            res.accepted      = string_verdict(lang_mode, trk);
            res.string_length = trk.sym_count;
            verdict_queue.push_back(res);
            trk = '0;
            return;
        end
        if (!symbol_taken(lang_mode, beat.symbol)) return;
        decimal_m = lang_mode == MODE_DEC_DIV3 || lang_mode == MODE_DEC_DIV4;
        if (beat.symbol <= SYM_MAX_BIN) begin
            bit_v  = beat.symbol[0];
            zero_v = ~bit_v;
            if (trk.sym_count >= 1 && trk.recent[0]) begin
                if (bit_v) trk.seen[0] = 1'b1;
                else trk.seen[1] = 1'b1;
            end
            if (zero_v && trk.sym_count >= 2 && trk.recent[1:0] == 2'b00) trk.seen[2] = 1'b1;
            if (trk.sym_count >= 4 && (int'(zero_v) + $countones(trk.zero_hist)) < 2)
                trk.violation = 1'b1;
            trk.zero_hist = {trk.zero_hist[2:0], zero_v};
            if (trk.sym_count == 0) trk.first_two[1] = bit_v;
            else if (trk.sym_count == 1) trk.first_two[0] = bit_v;
            trk.recent = {trk.recent[1:0], bit_v};
            if (zero_v) begin
                if (trk.zero_capped != 3'd7) trk.zero_capped = trk.zero_capped + 3'd1;
                trk.zero_par  = ~trk.zero_par;
                trk.zero_mod3 = (trk.zero_mod3 >= 2'd2) ? 2'd0 : trk.zero_mod3 + 2'd1;
            end else begin
                trk.one_par = ~trk.one_par;
            end
        end
        // Decimal digits feed the mod-3 residue as a digit sum; binary shifts it.
        if (decimal_m) trk.res3 = 2'((trk.res3 + sym) % 3);
        else trk.res3 = 2'((2 * trk.res3 + sym) % 3);
        trk.res4 = 2'((2 * trk.res4 + sym) % 4);
        trk.len_odd = ~trk.len_odd;
        if (trk.sym_count != STRING_LEN_MAX) trk.sym_count = trk.sym_count + 6'd1;
    endtask

    task automatic report_mismatch(string what);
        $display("check failed at %0t ns: %s", $time, what);
        fail_count++;
    endtask

    // Input driver: bursts of beats separated by random gaps.
    always @(posedge clk) begin : in_driver
        logic fire, nxt_valid;
        if (rst_n) begin
            fire = in_valid && in_ready;
            if (fire) begin
                apply_beat(in_beat);
                beats_taken++;
            end
            if (!in_valid || fire) begin
                nxt_valid = 1'b0;
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_beats.size() != 0) begin
                    in_beat <= pending_beats.pop_front();
                    nxt_valid = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                    end else begin
                        burst_left--;
                    end
                end
                in_valid <= nxt_valid;
            end
        end
    end

    // Result monitor; ready follows a rotating stall pattern.
    always @(posedge clk) begin : out_monitor
        t_msr_out want;
        if (rst_n && out_valid && out_ready) begin
            if (verdict_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected result %b len %0d",
                                          out_beat.accepted, out_beat.string_length));
            end else begin
                want = verdict_queue.pop_front();
                if (out_beat.accepted !== want.accepted)
                    report_mismatch($sformatf("accepted %b, predicted %b",
                                              out_beat.accepted, want.accepted));
                if (out_beat.string_length !== want.string_length)
                    report_mismatch($sformatf("length %0d, predicted %0d",
                                              out_beat.string_length, want.string_length));
            end
        end
        out_ready  <= recv_pattern[recv_phase];
        recv_phase <= recv_phase + 4'd1;
    end

    task automatic push_beat(logic [3:0] s, logic t);
        t_msr_in beat;
        beat.symbol     = s;
        beat.terminator = t;
        pending_beats.push_back(beat);
        beats_pushed++;
        if (t || symbol_taken(gen_mode, s)) useful_beats++;
    endtask

    task automatic push_string(int unsigned len, logic close);
        int unsigned one_pct;
        logic [3:0]  s;
        one_pct = $urandom_range(0, 2) * 35 + 15;
        for (int unsigned i = 0; i < len; i++) begin
            if (gen_mode >= MODE_STARTS_0 && gen_mode <= MODE_WINDOW_TWO0) begin
                if ($urandom_range(0, 11) == 0) s = 4'($urandom_range(2, 15));
                else s = ($urandom_range(1, 100) <= one_pct) ? 4'd1 : 4'd0;
            end else if (gen_mode == MODE_DEC_DIV3 || gen_mode == MODE_DEC_DIV4) begin
                if ($urandom_range(0, 11) == 0) s = 4'($urandom_range(10, 15));
                else s = 4'($urandom_range(0, 9));
            end else begin
                s = 4'($urandom_range(0, 15));
            end
            push_beat(s, 1'b0);
        end
        if (close) push_beat(4'($urandom_range(0, 15)), 1'b1);
    endtask

    // Waits until every beat is taken and every verdict seen, then lets the pipe settle.
    task automatic wait_idle();
        while (beats_taken != beats_pushed || verdict_queue.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode(logic [MODE_W-1:0] m);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        lang_mode = m;
        gen_mode  = m;
    endtask

    initial begin : stimulus
        int unsigned pick, n_strings;
        logic [MODE_W-1:0] m;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset mode, empty string, ignored symbols, invalid modes,
        // decimal digits and a mode change in the middle of a string.
        push_beat(4'd0, 1'b1);
        push_beat(4'd0, 1'b0);
        push_beat(4'd9, 1'b1);
        push_beat(4'd1, 1'b0);
        push_beat(4'd5, 1'b0);
        push_beat(4'd0, 1'b0);
        push_beat(4'd15, 1'b1);
        wait_idle();
        write_mode(MODE_TOP);
        push_beat(4'd0, 1'b0);
        push_beat(4'd15, 1'b0);
        push_beat(4'd1, 1'b0);
        push_beat(4'd0, 1'b1);
        wait_idle();
        write_mode(MODE_NONE);
        push_beat(4'd1, 1'b0);
        push_beat(4'd0, 1'b1);
        wait_idle();
        write_mode(MODE_DEC_DIV4);
        push_beat(4'd9, 1'b0);
        push_beat(4'd12, 1'b0);
        push_beat(4'd2, 1'b0);
        push_beat(4'd8, 1'b1);
        wait_idle();
        write_mode(MODE_WINDOW_TWO0);
        push_beat(4'd1, 1'b0);
        push_beat(4'd1, 1'b0);
        push_beat(4'd0, 1'b0);
        wait_idle();
        write_mode(MODE_DEC_DIV3);
        push_beat(4'd6, 1'b0);
        push_beat(4'd0, 1'b1);
        wait_idle();

        useful_beats = 0;
        while (useful_beats < USEFUL_BEATS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) m = $urandom_range(0, 1) ? MODE_STARTS_0 : MODE_DEC_DIV4;
            else if (pick == 1)
                m = $urandom_range(0, 1) ? MODE_NONE : MODE_W'($urandom_range(26, 31));
            else m = MODE_W'($urandom_range(1, 25));
            write_mode(m);

            case ($urandom_range(0, 2))
                0: gap_max <= 0;
                1: gap_max <= 3;
                default: gap_max <= 10;
            endcase
            case ($urandom_range(0, 2))
                0: recv_pattern <= 16'hFFFF;
                1: recv_pattern <= 16'($urandom | (32'h1 << $urandom_range(0, 15)));
                default: recv_pattern <= 16'(($urandom & $urandom)
                                             | (32'h1 << $urandom_range(0, 15)));
            endcase

            n_strings = $urandom_range(2, 8);
            for (int unsigned k = 0; k < n_strings; k++) begin
                // Now and then a long string, which may saturate the length count.
                if ($urandom_range(0, 24) == 0)
                    push_string($urandom_range(60, 80), 1'b1);
                else
                    push_string($urandom_range(0, 9),
                                k + 1 < n_strings || $urandom_range(0, 3) != 0);
            end
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("multi_mode_string_recognizer: match");
        end else begin
            $display("multi_mode_string_recognizer: mismatch");
        end
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("multi_mode_string_recognizer: mismatch");
        $finish;
    end

endmodule

// File: multi_mode_string_recognizer.f
hw/rtl/msr_pkg.sv
hw/rtl/msr_tracker.sv
hw/rtl/msr_verdict.sv
hw/rtl/multi_mode_string_recognizer.sv
hw/rtl/msr_checker.sv
bench/tb_multi_mode_string_recognizer.sv
